@@ rtl/core/pcf_pkg.sv @@
package pcf_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
	localparam int          BUF_DEPTH = 8;
	localparam int          CNT_W = $clog2(BUF_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_DATA  = 2'd1,
		OP_END   = 2'd2
	} pcf_op_t;

	// One group of output bytes handed from the framing stage to the serializer.
	typedef struct packed {
		logic                            valid;
		logic [CNT_W-1:0]                cnt;
		logic [BUF_DEPTH-1:0][7:0]       bytes;
		logic                            is_end;
		logic                            err;
	} pcf_load_t;

	function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/core/pcf_serializer.sv @@
module pcf_serializer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pcf_pkg::pcf_load_t    ld,
	output logic                  load_ok,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  last,
	output logic                  length_error
);
	import pcf_pkg::*;

	logic [BUF_DEPTH-1:0][7:0] buf_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      is_end_q;
	logic                      err_q;
	logic                      out_fire;
	logic                      do_load;

	assign out_valid    = (cnt_q != '0);
	assign out_fire     = out_valid && !out_stall;
	assign load_ok      = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && !out_stall);
	assign do_load      = ld.valid && load_ok;
	assign out_byte     = buf_q[0];
	assign last         = is_end_q && (cnt_q == CNT_W'(1));
	assign length_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			is_end_q <= 1'b0;
			err_q    <= 1'b0;
		end else if (do_load) begin
			cnt_q    <= ld.cnt;
			is_end_q <= ld.is_end;
			err_q    <= ld.err;
		end else if (out_fire) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			buf_q <= ld.bytes;
		end else if (out_fire) begin
			for (int i = 0; i < BUF_DEPTH - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
			buf_q[BUF_DEPTH-1] <= 8'd0;
		end
	end

endmodule

@@ rtl/core/png_chunk_framer_crc32_top.sv @@
// The input register takes a beat and the serializer buffer then loads its output bytes; the first
// output byte of a beat is valid once the buffer has loaded, which waits while earlier bytes are pending.
// Throughput: one output byte per cycle while out_stall is low; a data beat gives one byte,
// a start beat eight bytes and an end beat four, all sent through the single output byte port.
// Beats that cause no output leave the input register without waiting for the serializer.
// Reset (arst_n low) empties the pipeline, sets the CRC to all ones and closes any chunk.
module png_chunk_framer_crc32_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [30:0] chunk_length,
	input  logic [31:0] chunk_type,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        length_error
);
	import pcf_pkg::*;

	logic        valid_s1;
	logic [1:0]  opcode_s1;
	logic [30:0] length_s1;
	logic [31:0] type_s1;
	logic [7:0]  data_s1;

	logic [31:0] crc_q;
	logic [30:0] count_q;
	logic [30:0] decl_q;
	logic        in_chunk_q;

	logic [31:0] crc_d;
	logic [30:0] count_d;
	logic [30:0] decl_d;
	logic        in_chunk_d;
	logic [31:0] crc_out;
	logic [31:0] len32;

	pcf_load_t   ld;
	logic        load_ok;
	logic        s1_fire;
	logic        in_fire;

	assign in_fire  = in_valid && !in_stall;
	assign s1_fire  = valid_s1 && (load_ok || !ld.valid);
	assign in_stall = valid_s1 && !s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			opcode_s1 <= opcode;
			length_s1 <= chunk_length;
			type_s1   <= chunk_type;
			data_s1   <= data_byte;
		end
	end

	always_comb begin
		crc_d      = crc_q;
		count_d    = count_q;
		decl_d     = decl_q;
		in_chunk_d = in_chunk_q;
		crc_out    = ~crc_q;
		len32      = {1'b0, length_s1};
		ld         = '0;
		ld.valid   = 1'b0;
		case (opcode_s1)
			OP_START: begin
				ld.valid    = valid_s1;
				ld.cnt      = CNT_W'(8);
				ld.bytes[0] = len32[31:24];
				ld.bytes[1] = len32[23:16];
				ld.bytes[2] = len32[15:8];
				ld.bytes[3] = len32[7:0];
				ld.bytes[4] = type_s1[31:24];
				ld.bytes[5] = type_s1[23:16];
				ld.bytes[6] = type_s1[15:8];
				ld.bytes[7] = type_s1[7:0];
				crc_d = crc_fold_byte(crc_fold_byte(crc_fold_byte(crc_fold_byte(
					CRC_ONES, type_s1[31:24]), type_s1[23:16]), type_s1[15:8]),
					type_s1[7:0]);
				decl_d     = length_s1;
				count_d    = '0;
				in_chunk_d = 1'b1;
			end
			OP_DATA: begin
				if (in_chunk_q) begin
					ld.valid    = valid_s1;
					ld.cnt      = CNT_W'(1);
					ld.bytes[0] = data_s1;
					crc_d       = crc_fold_byte(crc_q, data_s1);
					if (count_q != '1) begin
						count_d = count_q + 31'd1;
					end
				end
			end
			OP_END: begin
				if (in_chunk_q) begin
					ld.valid    = valid_s1;
					ld.cnt      = CNT_W'(4);
					ld.bytes[0] = crc_out[31:24];
					ld.bytes[1] = crc_out[23:16];
					ld.bytes[2] = crc_out[15:8];
					ld.bytes[3] = crc_out[7:0];
					ld.is_end   = 1'b1;
					ld.err      = (count_q != decl_q);
					in_chunk_d  = 1'b0;
					crc_d       = CRC_ONES;
					count_d     = '0;
				end
			end
			default: begin
				ld.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_ONES;
			count_q    <= '0;
			decl_q     <= '0;
			in_chunk_q <= 1'b0;
		end else if (s1_fire) begin
			crc_q      <= crc_d;
			count_q    <= count_d;
			decl_q     <= decl_d;
			in_chunk_q <= in_chunk_d;
		end
	end

	pcf_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld           (ld),
		.load_ok      (load_ok),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last         (last),
		.length_error (length_error)
	);

endmodule

@@ rtl/core/pcf_checker.sv @@
module pcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  opcode,
	input logic [30:0] chunk_length,
	input logic [31:0] chunk_type,
	input logic [7:0]  data_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        last,
	input logic        length_error
);

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last)
			&& $stable(length_error))
		else $error("stalled output beat changed");

	// The input only backs up while output bytes are still pending.
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with nothing pending at the output");

	// Output starts only from an input beat that was taken earlier.
	a_rise_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output appeared without an input beat");

endmodule

bind png_chunk_framer_crc32_top pcf_checker u_pcf_checker (.*);
